// ===== design/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants of the signed radix to ASCII converter: the
// payload structs of both channels, the controller/datapath command and
// status structs, and the character codes.
// ----------------------------------------------------------------------------
package sra_pkg;

   // Width of the signed input value.
   localparam int DATA_WIDTH = 32;
   localparam int RADIX_W    = 5;
   localparam int CHAR_W     = 7;
   localparam int DIGIT_W    = 4;

   // The digit divider consumes this many dividend bits per cycle.
   localparam int STEP_BITS  = 8;
   localparam int NUM_CHUNKS = (DATA_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int MAG_W      = NUM_CHUNKS * STEP_BITS;
   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam logic [CHUNK_W-1:0] CHUNK_TOP = CHUNK_W'(NUM_CHUNKS - 1);

   // Digit store addressing and digit count (the count may reach DATA_WIDTH).
   localparam int ADDR_W = $clog2(DATA_WIDTH);
   localparam int CNT_W  = $clog2(DATA_WIDTH + 1);

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic [RADIX_W-1:0]           radix;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;       // load a new number
      logic step;        // run one divider chunk
      logic load_sign;   // put '-' into the output register
      logic load_digit;  // put the current stored digit into the output register
   } sra_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic digit_done;  // the divider finishes a digit this cycle
      logic quo_zero;    // the quotient left by that digit is zero
      logic out_free;    // the output register can take a character this cycle
      logic neg;         // the number is negative
      logic last_digit;  // the digit at the read pointer is the final one
   } sra_sts_type;

endpackage

// ===== design/sra_ctrl.sv =====
// ----------------------------------------------------------------------------
// sra_ctrl
// Controller of the converter: sequences the digit division, the optional
// sign character and the most-significant-first readout of the digits.
// ----------------------------------------------------------------------------
module sra_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sra_pkg::sra_sts_type sts,
   output sra_pkg::sra_cmd_type cmd
);
   import sra_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_comb begin
      cmd            = '0;
      cmd.start      = req_valid && ready_ff;
      cmd.step       = (state_ff == ST_DIVIDE);
      cmd.load_sign  = (state_ff == ST_SIGN) && sts.neg && sts.out_free;
      cmd.load_digit = (state_ff == ST_DIGITS) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= ST_DIVIDE;
                  ready_ff <= 1'b0;
               end
            end
            ST_DIVIDE: begin
               if (sts.digit_done && sts.quo_zero) begin
                  state_ff <= ST_SIGN;
               end
            end
            ST_SIGN: begin
               // A non-negative number passes straight through this state, which also lets the
               // digit store read settle after the final digit write.
               if (!sts.neg || sts.out_free) begin
                  state_ff <= ST_DIGITS;
               end
            end
            ST_DIGITS: begin
               if (sts.out_free && sts.last_digit) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;

endmodule

// ===== design/sra_datapath.sv =====
// ----------------------------------------------------------------------------
// sra_datapath
// Datapath of the converter: magnitude register with an in-place chunked
// divider by the radix, the digit store, and the output register.
// ----------------------------------------------------------------------------
module sra_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sra_pkg::req_type     req_data,
   input  sra_pkg::sra_cmd_type cmd,
   output sra_pkg::sra_sts_type sts,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output sra_pkg::rsp_type     rsp_data
);
   import sra_pkg::*;

   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff;
   logic               neg_ff;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [DIGIT_W-1:0] rdata_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [DIGIT_W-1:0] digit_store [DATA_WIDTH];

   logic [DATA_WIDTH-1:0] raw_value;
   logic [DATA_WIDTH-1:0] abs_value;
   logic [RADIX_W-1:0]    radix_clamped;
   logic [STEP_BITS-1:0]  q_bits;
   logic [DIGIT_W-1:0]    rem_step;
   logic                  digit_done;

   assign raw_value = req_data.value;
   assign abs_value = raw_value[DATA_WIDTH-1] ? (~raw_value + 1'b1) : raw_value;

   always_comb begin
      if (req_data.radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_data.radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_data.radix;
      end
   end

   // Long division of one chunk by the radix, most significant bit first.
   // The partial remainder restarts from zero at the top chunk of each digit.
   always_comb begin
      logic [STEP_BITS-1:0] chunk_bits;
      logic [DIGIT_W:0]     trial;
      logic [DIGIT_W-1:0]   r;
      chunk_bits = mag_ff[chunk_ff*STEP_BITS +: STEP_BITS];
      r          = (chunk_ff == CHUNK_TOP) ? '0 : rem_ff;
      q_bits     = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {r, chunk_bits[i]};
         if (trial >= radix_ff) begin
            trial     = trial - radix_ff;
            q_bits[i] = 1'b1;
         end
         r = trial[DIGIT_W-1:0];
      end
      rem_step = r;
   end

   assign digit_done = cmd.step && (chunk_ff == '0);

   always_comb begin
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      chunk_in  = chunk_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.start) begin
         mag_in   = MAG_W'(abs_value);
         chunk_in = CHUNK_TOP;
         count_in = '0;
      end else if (cmd.step) begin
         // Quotient bits replace the dividend bits they were taken from.
         mag_in[chunk_ff*STEP_BITS +: STEP_BITS] = q_bits;
         rem_in = rem_step;
         if (chunk_ff == '0) begin
            chunk_in  = CHUNK_TOP;
            count_in  = count_ff + 1'b1;
            rd_idx_in = count_ff[ADDR_W-1:0];
         end else begin
            chunk_in = chunk_ff - 1'b1;
         end
      end else if (cmd.load_digit) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff    <= '0;
         neg_ff    <= 1'b0;
         chunk_ff  <= CHUNK_TOP;
         count_ff  <= '0;
         rd_idx_ff <= '0;
      end else begin
         mag_ff    <= mag_in;
         chunk_ff  <= chunk_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         if (cmd.start) begin
            neg_ff <= raw_value[DATA_WIDTH-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (cmd.start) begin
         radix_ff <= radix_clamped;
      end
   end

   // Digit store: the read address is the next pointer value, so the read data
   // matches the entry at the current pointer, except after a write to that entry.
   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_store[count_ff[ADDR_W-1:0]] <= rem_step;
      end
      rdata_ff <= digit_store[rd_idx_in];
   end

   assign sts.digit_done = digit_done;
   assign sts.quo_zero   = (mag_in == '0);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.neg        = neg_ff;
   assign sts.last_digit = (rd_idx_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_sign || cmd.load_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sign) begin
         rsp_ff.char_code <= CHAR_MINUS;
         rsp_ff.last_char <= 1'b0;
      end else if (cmd.load_digit) begin
         rsp_ff.char_code <= DIGIT_CHARS[rdata_ff];
         rsp_ff.last_char <= (rd_idx_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_digit_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_digit |-> (!rsp_valid_ff || rsp_ready))
      else $error("digit loaded while the output register is occupied");

   a_sign_only_negative: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sign |-> (neg_ff && !cmd.load_digit && !cmd.step))
      else $error("sign character loaded for a non-negative number");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      digit_done |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("digit count did not advance after a finished digit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      digit_done |-> (count_ff < CNT_W'(DATA_WIDTH)))
      else $error("digit store would overflow");
`endif

endmodule

// ===== design/signed_radix_to_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_ascii
// Converts a signed integer into its ASCII text in a radix from 2 to 16,
// one character per result transfer, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: value (signed) and radix; radix values below 2 act as 2 and
//   values above 16 act as 16. A transfer is taken only while req_ready is
//   high, which is while no earlier number is still being converted.
//   rsp channel: one char_code per character, '-' first for a negative
//   number, then the digits 0-9/A-F; last_char marks the final one. Zero
//   gives the single character '0'.
// Timing:
//   Each digit is divided out chunk by chunk in the divider (8 dividend bits per
//   cycle over the 32-bit magnitude); after the last digit the sign stage runs,
//   then the characters follow at one per cycle while the receiver keeps up.
//   req_ready rises again once the final character is in the output register.
// Reset: synchronous; clears the controller, the output valid and the counters.
// A stall on rsp holds the output register and pauses the readout.
// ----------------------------------------------------------------------------
module signed_radix_to_ascii (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sra_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sra_pkg::rsp_type rsp_data
);
   import sra_pkg::*;

   sra_cmd_type cmd;
   sra_sts_type sts;

   sra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sra_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
